FILE: sv/hia_pkg.sv
// shared constants and types for the handle index allocator
package hia_pkg;

  localparam int unsigned IndexBits   = 12;
  localparam int unsigned SegmentBits = 6;
  localparam int unsigned DataWidth   = 64;

  localparam int unsigned WordBits    = 64;
  localparam int unsigned OffBits     = 6;
  localparam int unsigned RowBits     = IndexBits - OffBits;
  localparam int unsigned NumRows     = 1 << RowBits;
  localparam int unsigned NumIndices  = 1 << IndexBits;
  localparam int unsigned SegBits     = IndexBits - SegmentBits;
  localparam int unsigned NumSegments = 1 << SegBits;
  localparam int unsigned CountBits   = RowBits + 1;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_FAIL     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ACCESS
  } state_e;

endpackage

FILE: sv/handle_index_allocator_unit.sv
// handle table with next-fit bitmap allocation over a usage bitmap memory
//
//  channel   | signals                                 | handshake
//  ----------+-----------------------------------------+------------------------------
//  command   | start, busy, opcode_i, slot_i, payload_i | transfer when start && !busy
//  result    | done_o, status_o, granted_slot_o,       | one-cycle strobe, no stall
//            | read_word_o                             |
//
//  allocate issues the first bitmap read, then examines one bitmap word at a time
//  (up to 65 with the wrap), paced by the single bitmap read port.
//  free and lookup read first, then a free writes back; a bad opcode answers from idle.
//  after reset the bitmap words read as zero through per-word valid flops; the entry
//  store is never cleared, a stored word only counts while its usage bit is set.
//  the result is shown for one cycle and cannot be held off by the receiver.
module handle_index_allocator_unit
  import hia_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           opcode_i,
  input  logic [IndexBits-1:0] slot_i,
  input  logic [DataWidth-1:0] payload_i,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [IndexBits-1:0] granted_slot_o,
  output logic [DataWidth-1:0] read_word_o
);

  state_e state_q, state_d;

  logic [IndexBits-1:0] cursor_q, cursor_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  opcode_e              op_q;
  logic [IndexBits-1:0] slot_q;
  logic [DataWidth-1:0] payload_q;
  logic [NumSegments-1:0] seg_q, seg_d;
  logic [NumRows-1:0]   row_valid_q, row_valid_d;

  logic                 done_q, done_d;
  status_e              status_q, status_d;
  logic [IndexBits-1:0] granted_q, granted_d;
  logic [DataWidth-1:0] word_q, word_d;

  // memories
  logic [WordBits-1:0]  used_mem [NumRows];
  logic [DataWidth-1:0] entry_mem [NumIndices];

  logic                 used_we;
  logic [RowBits-1:0]   used_waddr, used_raddr;
  logic [WordBits-1:0]  used_wdata;
  logic [WordBits-1:0]  used_rdata_q;
  logic                 row_valid_rd_q;
  logic                 entry_we;
  logic [IndexBits-1:0] entry_waddr;
  logic [DataWidth-1:0] entry_rdata_q;

  logic                 accept;
  logic [WordBits-1:0]  row;
  logic [WordBits-1:0]  below;
  logic [WordBits-1:0]  clear_bits;
  logic [OffBits-1:0]   low_pos;
  logic [RowBits-1:0]   scan_row;
  logic [IndexBits-1:0] found_idx;
  logic [OffBits-1:0]   slot_off;
  logic                 present;
  logic                 slot_used;

  assign accept   = start && !busy;
  assign busy     = (state_q != S_IDLE);
  assign row      = row_valid_rd_q ? used_rdata_q : '0;
  assign below    = (WordBits'(1) << cursor_q[OffBits-1:0]) - WordBits'(1);
  assign scan_row = cursor_q[IndexBits-1:OffBits] + cnt_q[RowBits-1:0];
  assign slot_off = slot_q[OffBits-1:0];
  assign present  = seg_q[slot_q[IndexBits-1:SegmentBits]];
  assign slot_used = row[slot_off];

  always_comb begin
    clear_bits = ~row;
    if (cnt_q == '0) begin
      clear_bits = clear_bits & ~below;
    end
    if (cnt_q == CountBits'(NumRows)) begin
      clear_bits = clear_bits & below;
    end
  end

  // lowest clear position in the examined word
  always_comb begin
    low_pos = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (clear_bits[i]) begin
        low_pos = OffBits'(i);
      end
    end
  end

  assign found_idx = {scan_row, low_pos};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_ALLOC:            state_d = S_SCAN;
            OP_FREE, OP_LOOKUP:  state_d = S_ACCESS;
            default:             state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (clear_bits != '0 || cnt_q == CountBits'(NumRows)) begin
          state_d = S_IDLE;
        end
      end
      S_ACCESS: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    cursor_d    = cursor_q;
    cnt_d       = cnt_q;
    seg_d       = seg_q;
    row_valid_d = row_valid_q;
    done_d      = 1'b0;
    status_d    = ST_FAIL;
    granted_d   = '0;
    word_d      = '0;
    used_we     = 1'b0;
    used_waddr  = slot_q[IndexBits-1:OffBits];
    used_wdata  = row & ~(WordBits'(1) << slot_off);
    used_raddr  = scan_row + RowBits'(1);
    entry_we    = 1'b0;
    entry_waddr = found_idx;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (opcode_i == OP_ALLOC) begin
          used_raddr = cursor_q[IndexBits-1:OffBits];
        end else begin
          used_raddr = slot_i[IndexBits-1:OffBits];
        end
        if (accept && !(opcode_i inside {OP_ALLOC, OP_FREE, OP_LOOKUP})) begin
          done_d = 1'b1;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + CountBits'(1);
        if (clear_bits != '0) begin
          used_we     = 1'b1;
          used_waddr  = scan_row;
          used_wdata  = row | (WordBits'(1) << low_pos);
          row_valid_d[scan_row] = 1'b1;
          entry_we    = 1'b1;
          seg_d[found_idx[IndexBits-1:SegmentBits]] = 1'b1;
          cursor_d    = found_idx + IndexBits'(1);
          done_d      = 1'b1;
          status_d    = ST_OK;
          granted_d   = found_idx;
        end else if (cnt_q == CountBits'(NumRows)) begin
          done_d   = 1'b1;
          status_d = ST_NO_SPACE;
        end
      end
      S_ACCESS: begin
        done_d = 1'b1;
        if (op_q == OP_FREE) begin
          if (present) begin
            used_we  = 1'b1;
            row_valid_d[slot_q[IndexBits-1:OffBits]] = 1'b1;
            status_d = ST_OK;
          end
        end else if (present && slot_used && entry_rdata_q != '0) begin
          status_d = ST_OK;
          word_d   = entry_rdata_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cursor_q    <= '0;
      cnt_q       <= '0;
      seg_q       <= '0;
      row_valid_q <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      cnt_q       <= cnt_d;
      seg_q       <= seg_d;
      row_valid_q <= row_valid_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= opcode_e'(opcode_i);
      slot_q    <= slot_i;
      payload_q <= payload_i;
    end
    status_q  <= status_d;
    granted_q <= granted_d;
    word_q    <= word_d;
  end

  // bitmap memory, valid flop read alongside the word
  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_mem[used_waddr] <= used_wdata;
    end
    used_rdata_q   <= used_mem[used_raddr];
    row_valid_rd_q <= row_valid_q[used_raddr];
  end

  // entry store
  always_ff @(posedge clk_i) begin
    if (entry_we) begin
      entry_mem[entry_waddr] <= payload_q;
    end
    entry_rdata_q <= entry_mem[slot_i];
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign granted_slot_o = granted_q;
  assign read_word_o    = word_q;

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> granted_slot_o == '0 && read_word_o == '0)
    else $error("failed result carries data");

  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN && cnt_q == CountBits'(NumRows) |=> state_q == S_IDLE && done_o)
    else $error("scan ran past the wrap");

  a_cursor_follow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_OK && $past(state_q == S_SCAN)
      |-> cursor_q == granted_slot_o + IndexBits'(1))
    else $error("cursor not after granted index");

  a_accept_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted command dropped");

endmodule
